// File: rtl/core/sph_pkg.sv
// Shared types, fixed-point constants and helpers for the sphere collide pipeline.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package sph_pkg;

	localparam int COORD_W    = 24;
	localparam int COORD_FRAC = 12;
	localparam int COEF_FRAC  = 8;
	localparam int GAIN_W     = 32;
	localparam int GAIN_FRAC  = 16;
	localparam int MAG_W      = COORD_FRAC;
	localparam int NORM_SHIFT = 16;
	localparam int SQ_W       = 2 * MAG_W + NORM_SHIFT;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int DIV_SHIFT  = 20;
	localparam int NUM_W      = MAG_W + DIV_SHIFT + 1;
	localparam int QUO_W      = 14;
	localparam int AFF_LAT    = 2;
	localparam int PIPE_LAT   = 2 * AFF_LAT + 2 + ROOT_W + QUO_W + 3;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_ONE = coord_t'(1 << COORD_FRAC);

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
	} pos_t;

	typedef struct packed {
		coord_t new_x;
		coord_t new_y;
		coord_t new_z;
		logic   inside_flag;
	} res_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		vec_t v;
		logic in_sphere;
	} side_t;

	typedef logic signed [QUO_W:0] unit_t;

	typedef struct packed {
		unit_t ux;
		unit_t uy;
		unit_t uz;
	} uvec_t;

	typedef enum logic [2:0] {
		REG_FWD_A,
		REG_FWD_B,
		REG_FWD_C,
		REG_BACK_A,
		REG_BACK_B,
		REG_BACK_C,
		REG_GAIN
	} reg_idx_t;

	// Clamps a wide signed value to the coordinate range.
	function automatic coord_t sat_coord(input logic signed [63:0] x);
		coord_t hi;
		coord_t lo;
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		if (x > 64'(hi)) begin
			return hi;
		end else if (x < 64'(lo)) begin
			return lo;
		end
		return x[COORD_W-1:0];
	endfunction

endpackage

// File: rtl/core/sphere_collide_point_projection.sv
// Top level of the sphere collide point projection pipeline and its register file.
// Depends on sph_pkg, sph_affine, sph_isqrt and sph_div.

// One vertex item enters per clock whenever start is high; busy is always low, so
// every cycle can carry a new item. Each item is mapped into collider space, pushed
// onto the unit sphere (optionally scaled by the gain) when it lies strictly inside,
// mapped back and presented on res for exactly one cycle with done high. Its path
// runs through the square root (one root bit per stage, 20 stages) and the
// normalizing divider (one quotient bit per stage, 14 stages), plus two stages for
// each affine transform, two for the length test and three for the gain. Results
// are never held back, so the receiver must take them as they come. Coefficient and
// gain registers sit on the APB port at 8-byte spacing and must be written only
// while no items are in flight.
module sphere_collide_point_projection #(
	parameter int COEF_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sph_pkg::pos_t pos,
	output logic          done,
	output sph_pkg::res_t res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int MW = sph_pkg::MAG_W;
	localparam int PRW = sph_pkg::QUO_W + 1 + sph_pkg::GAIN_W;

	logic [63:0] fwd_a_q, fwd_b_q, fwd_c_q, back_a_q, back_b_q, back_c_q;
	logic signed [sph_pkg::GAIN_W-1:0] gain_q;
	sph_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	// Register file.
	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = sph_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_a_q  <= 64'd256;
			fwd_b_q  <= 64'd256;
			fwd_c_q  <= 64'd256;
			back_a_q <= 64'd256;
			back_b_q <= 64'd256;
			back_c_q <= 64'd256;
			gain_q   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				sph_pkg::REG_FWD_A:  fwd_a_q  <= pwdata;
				sph_pkg::REG_FWD_B:  fwd_b_q  <= pwdata;
				sph_pkg::REG_FWD_C:  fwd_c_q  <= pwdata;
				sph_pkg::REG_BACK_A: back_a_q <= pwdata;
				sph_pkg::REG_BACK_B: back_b_q <= pwdata;
				sph_pkg::REG_BACK_C: back_c_q <= pwdata;
				sph_pkg::REG_GAIN:   gain_q   <= pwdata[sph_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sph_pkg::REG_FWD_A:  prdata = fwd_a_q;
			sph_pkg::REG_FWD_B:  prdata = fwd_b_q;
			sph_pkg::REG_FWD_C:  prdata = fwd_c_q;
			sph_pkg::REG_BACK_A: prdata = back_a_q;
			sph_pkg::REG_BACK_B: prdata = back_b_q;
			sph_pkg::REG_BACK_C: prdata = back_c_q;
			sph_pkg::REG_GAIN:   prdata = {32'd0, gain_q};
			default:             prdata = '0;
		endcase
	end

	// Forward transform into collider space.
	logic          fwd_valid, fwd_tag;
	sph_pkg::vec_t fwd_vec;

	sph_affine #(.COEF_WIDTH(COEF_WIDTH)) u_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_tag   (1'b0),
		.in_vec   ('{x: pos.pos_x, y: pos.pos_y, z: pos.pos_z}),
		.coef_a   (fwd_a_q),
		.coef_b   (fwd_b_q),
		.coef_c   (fwd_c_q),
		.out_valid(fwd_valid),
		.out_tag  (fwd_tag),
		.out_vec  (fwd_vec)
	);

	// Length test: squares of the component magnitudes, then their sum.
	// A component of magnitude one or more makes the point outside at once.
	sph_pkg::coord_t   fc [3];
	logic [2*MW-1:0]   sq_s1 [3];
	logic              small_s1, valid_s1;
	sph_pkg::vec_t     v_s1;
	logic [2*MW+1:0]   len2;
	logic [sph_pkg::SQ_W-1:0] n_s2;
	sph_pkg::side_t    side_s2;
	logic              valid_s2;

	always_comb begin
		fc[0] = fwd_vec.x;
		fc[1] = fwd_vec.y;
		fc[2] = fwd_vec.z;
		len2 = (2*MW+2)'(sq_s1[0]) + (2*MW+2)'(sq_s1[1]) + (2*MW+2)'(sq_s1[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= fwd_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sph_pkg::coord_t a;
		logic            sm;
		sm = 1'b1;
		for (int j = 0; j < 3; j++) begin
			a = fc[j][sph_pkg::COORD_W-1] ? -fc[j] : fc[j];
			sq_s1[j] <= (2*MW)'(a[MW-1:0]) * (2*MW)'(a[MW-1:0]);
			sm = sm && (fc[j] < sph_pkg::COORD_ONE) && (fc[j] > -sph_pkg::COORD_ONE);
		end
		small_s1 <= sm;
		v_s1     <= fwd_vec;
		n_s2     <= {len2[2*MW-1:0], {sph_pkg::NORM_SHIFT{1'b0}}};
		side_s2  <= '{v: v_s1, in_sphere: small_s1 && (len2[2*MW+1:2*MW] == 2'b00)};
	end

	// Root of the squared length in Q.20, then the three normalizing divides.
	logic                       sq_valid;
	logic [sph_pkg::ROOT_W-1:0] sq_root;
	sph_pkg::side_t             sq_side;
	logic                       dv_valid;
	sph_pkg::uvec_t             dv_unit;
	sph_pkg::side_t             dv_side;

	sph_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_n     (n_s2),
		.in_side  (side_s2),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	sph_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.in_len   (sq_root),
		.in_side  (sq_side),
		.out_valid(dv_valid),
		.out_unit (dv_unit),
		.out_side (dv_side)
	);

	// Gain: register unit vector; for nonzero gain multiply, round half up and clamp.
	sph_pkg::unit_t        u_s3 [3];
	sph_pkg::unit_t        u_s4 [3];
	logic signed [PRW-1:0] prod_s4 [3];
	sph_pkg::side_t        side_s3, side_s4;
	logic                  valid_s3, valid_s4, valid_s5, in_sphere_s5;
	sph_pkg::coord_t       r_c [3];
	sph_pkg::vec_t         vec_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= dv_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		u_s3[0] <= dv_unit.ux;
		u_s3[1] <= dv_unit.uy;
		u_s3[2] <= dv_unit.uz;
		side_s3 <= dv_side;
		for (int j = 0; j < 3; j++) begin
			u_s4[j]    <= u_s3[j];
			prod_s4[j] <= PRW'(u_s3[j]) * PRW'(gain_q);
		end
		side_s4      <= side_s3;
		vec_s5       <= side_s4.in_sphere ? '{x: r_c[0], y: r_c[1], z: r_c[2]} : side_s4.v;
		in_sphere_s5 <= side_s4.in_sphere;
	end

	always_comb begin
		logic signed [PRW-1:0] rs;
		for (int j = 0; j < 3; j++) begin
			rs = (prod_s4[j] + (PRW'(1) <<< (sph_pkg::GAIN_FRAC - 1))) >>> sph_pkg::GAIN_FRAC;
			if (gain_q != '0) begin
				r_c[j] = sph_pkg::sat_coord(64'(rs));
			end else begin
				r_c[j] = sph_pkg::coord_t'(u_s4[j]);
			end
		end
	end

	// Return transform; its output registers drive the result ports directly.
	logic          back_valid, back_tag;
	sph_pkg::vec_t back_vec;

	sph_affine #(.COEF_WIDTH(COEF_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s5),
		.in_tag   (in_sphere_s5),
		.in_vec   (vec_s5),
		.coef_a   (back_a_q),
		.coef_b   (back_b_q),
		.coef_c   (back_c_q),
		.out_valid(back_valid),
		.out_tag  (back_tag),
		.out_vec  (back_vec)
	);

	assign done = back_valid;
	assign res  = '{new_x: back_vec.x, new_y: back_vec.y, new_z: back_vec.z,
	                inside_flag: back_tag};

	// The pipeline has a fixed latency: every result comes from an item taken
	// exactly that many cycles earlier, and every item yields one result.
	// The forward stage never carries a tag, so stray tag state cannot leak.
`ifndef NO_ASSERTIONS
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, sph_pkg::PIPE_LAT))
		else $error("result without an item taken at the pipeline latency");

	a_item_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(sph_pkg::PIPE_LAT) done)
		else $error("item taken but no result after the pipeline latency");

	a_in_sphere_small: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && side_s2.in_sphere) |-> $past(small_s1))
		else $error("inside flag set for a point with a large component");

	a_fwd_tag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid |-> !fwd_tag)
		else $error("forward transform delivered a set tag");
`endif

endmodule

// File: rtl/core/sph_affine.sv
// Two-stage affine transform, row vector times 3x3 Q8.8 matrix plus translation.
// Depends on sph_pkg for the vector type and the saturation helper.
module sph_affine #(
	parameter int COEF_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_tag,
	input  sph_pkg::vec_t in_vec,
	input  logic [63:0]   coef_a,
	input  logic [63:0]   coef_b,
	input  logic [63:0]   coef_c,
	output logic          out_valid,
	output logic          out_tag,
	output sph_pkg::vec_t out_vec
);

	localparam int PW = sph_pkg::COORD_W + COEF_WIDTH;
	localparam int SW = PW + 2;

	logic [15:0]                  half [12];
	logic signed [COEF_WIDTH-1:0] m [12];
	sph_pkg::coord_t              p [3];
	logic signed [PW-1:0]         prod_s1 [9];
	logic                         valid_s1, valid_s2, tag_s1, tag_s2;
	sph_pkg::coord_t              o_c [3];
	sph_pkg::vec_t                vec_s2;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			half[k]     = coef_a[16*k +: 16];
			half[4 + k] = coef_b[16*k +: 16];
			half[8 + k] = coef_c[16*k +: 16];
		end
		for (int k = 0; k < 12; k++) begin
			m[k] = half[k][COEF_WIDTH-1:0];
		end
		p[0] = in_vec.x;
		p[1] = in_vec.y;
		p[2] = in_vec.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[3*r + c] <= PW'(p[r]) * PW'(m[3*r + c]);
			end
		end
		tag_s2 <= tag_s1;
		vec_s2 <= '{x: o_c[0], y: o_c[1], z: o_c[2]};
	end

	// Column sums in Q.20, rounded half up to Q.12 and clamped.
	always_comb begin
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] sh;
		for (int c = 0; c < 3; c++) begin
			sum = SW'(prod_s1[c]) + SW'(prod_s1[3 + c]) + SW'(prod_s1[6 + c])
			    + (SW'(m[9 + c]) <<< sph_pkg::COORD_FRAC)
			    + (SW'(1) <<< (sph_pkg::COEF_FRAC - 1));
			sh = sum >>> sph_pkg::COEF_FRAC;
			o_c[c] = sph_pkg::sat_coord(64'(sh));
		end
	end

	assign out_valid = valid_s2;
	assign out_tag   = tag_s2;
	assign out_vec   = vec_s2;

endmodule

// File: rtl/core/sph_isqrt.sv
// Pipelined integer square root, one result bit per stage, remainder form.
// Depends on sph_pkg for widths and the sideband type.
module sph_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [sph_pkg::SQ_W-1:0]    in_n,
	input  sph_pkg::side_t              in_side,
	output logic                        out_valid,
	output logic [sph_pkg::ROOT_W-1:0]  out_root,
	output sph_pkg::side_t              out_side
);

	localparam int RW = sph_pkg::ROOT_W;
	localparam int NW = sph_pkg::SQ_W;

	logic [NW-1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	sph_pkg::side_t  side_s [RW];
	logic            valid_s [RW];
	logic [NW-1:0]   rem_n  [RW];
	logic [RW-1:0]   root_n [RW];

	// Stage i settles bit RW-1-i of the root; the remainder is n minus root squared.
	always_comb begin
		logic [NW-1:0] r_in;
		logic [RW-1:0] q_in;
		logic [NW:0]   trial;
		for (int i = 0; i < RW; i++) begin
			if (i == 0) begin
				r_in = in_n;
				q_in = '0;
			end else begin
				r_in = rem_s[i-1];
				q_in = root_s[i-1];
			end
			trial = ((NW+1)'(q_in) << (RW - i)) + ((NW+1)'(1) << (2 * (RW - 1 - i)));
			if ((NW+1)'(r_in) >= trial) begin
				rem_n[i]  = NW'((NW+1)'(r_in) - trial);
				root_n[i] = q_in | (RW'(1) << (RW - 1 - i));
			end else begin
				rem_n[i]  = r_in;
				root_n[i] = q_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RW; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			valid_s[0] <= in_valid;
			for (int i = 1; i < RW; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int i = 1; i < RW; i++) begin
			side_s[i] <= side_s[i-1];
		end
		for (int i = 0; i < RW; i++) begin
			rem_s[i]  <= rem_n[i];
			root_s[i] <= root_n[i];
		end
	end

	assign out_valid = valid_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

// File: rtl/core/sph_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, for normalization.
// Depends on sph_pkg for widths, the sideband type and the unit vector type.
module sph_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [sph_pkg::ROOT_W-1:0]  in_len,
	input  sph_pkg::side_t              in_side,
	output logic                        out_valid,
	output sph_pkg::uvec_t              out_unit,
	output sph_pkg::side_t              out_side
);

	localparam int QW = sph_pkg::QUO_W;
	localparam int DW = sph_pkg::NUM_W;
	localparam int RW = sph_pkg::ROOT_W;

	logic [DW-1:0]   rem_s [QW][3];
	logic [QW-1:0]   q_s   [QW][3];
	logic [RW-1:0]   len_s [QW];
	sph_pkg::side_t  side_s [QW];
	logic            valid_s [QW];
	logic [DW-1:0]   rem_n [QW][3];
	logic [QW-1:0]   q_n   [QW][3];
	logic [DW-1:0]   num   [3];
	sph_pkg::coord_t comp  [3];
	sph_pkg::coord_t last_c [3];
	sph_pkg::unit_t  u     [3];

	// Dividend is the magnitude in Q.32 plus half the divisor, for round half away.
	always_comb begin
		sph_pkg::coord_t a;
		comp[0] = in_side.v.x;
		comp[1] = in_side.v.y;
		comp[2] = in_side.v.z;
		for (int j = 0; j < 3; j++) begin
			a = comp[j][sph_pkg::COORD_W-1] ? -comp[j] : comp[j];
			num[j] = (DW'(a[sph_pkg::MAG_W-1:0]) << sph_pkg::DIV_SHIFT) + DW'(in_len >> 1);
		end
	end

	always_comb begin
		logic [DW-1:0] r_in;
		logic [QW-1:0] q_in;
		logic [RW-1:0] d_in;
		logic [DW:0]   trial;
		for (int i = 0; i < QW; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (i == 0) begin
					r_in = num[j];
					q_in = '0;
					d_in = in_len;
				end else begin
					r_in = rem_s[i-1][j];
					q_in = q_s[i-1][j];
					d_in = len_s[i-1];
				end
				trial = (DW+1)'(d_in) << (QW - 1 - i);
				if ((DW+1)'(r_in) >= trial) begin
					rem_n[i][j] = DW'((DW+1)'(r_in) - trial);
					q_n[i][j]   = q_in | (QW'(1) << (QW - 1 - i));
				end else begin
					rem_n[i][j] = r_in;
					q_n[i][j]   = q_in;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			valid_s[0] <= in_valid;
			for (int i = 1; i < QW; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		len_s[0]  <= in_len;
		for (int i = 1; i < QW; i++) begin
			side_s[i] <= side_s[i-1];
			len_s[i]  <= len_s[i-1];
		end
		for (int i = 0; i < QW; i++) begin
			for (int j = 0; j < 3; j++) begin
				rem_s[i][j] <= rem_n[i][j];
				q_s[i][j]   <= q_n[i][j];
			end
		end
	end

	// A zero-length vector has a zero root and normalizes to zero.
	always_comb begin
		last_c[0] = side_s[QW-1].v.x;
		last_c[1] = side_s[QW-1].v.y;
		last_c[2] = side_s[QW-1].v.z;
		for (int j = 0; j < 3; j++) begin
			if (len_s[QW-1] == '0) begin
				u[j] = '0;
			end else if (last_c[j][sph_pkg::COORD_W-1]) begin
				u[j] = -sph_pkg::unit_t'({1'b0, q_s[QW-1][j]});
			end else begin
				u[j] = sph_pkg::unit_t'({1'b0, q_s[QW-1][j]});
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_unit  = '{ux: u[0], uy: u[1], uz: u[2]};
	assign out_side  = side_s[QW-1];

endmodule
